### hw/rtl/dmn_pkg.sv
package dmn_pkg;

	// Fixed field widths of the channels
	localparam int CMD_W      = 2;
	localparam int NODE_W     = 3;
	localparam int STAMP_W    = 16;
	localparam int KIND_W     = 2;
	localparam int CNT_W      = 4;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 4;

	// Default parameter values
	localparam int MAX_NODES_DEF  = 8;
	localparam int CLOCK_BITS_DEF = 16;

	// Largest participant count the node bitmaps can hold
	localparam int NODE_SLOTS_CAP = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_WANT    = 2'd0,
		CMD_REQUEST = 2'd1,
		CMD_REPLY   = 2'd2,
		CMD_LEAVE   = 2'd3
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_REQUEST = 2'd0,
		KIND_REPLY   = 2'd1,
		KIND_ENTERED = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_RELEASED = 2'd0,
		MODE_WAITING  = 2'd1,
		MODE_INSIDE   = 2'd2
	} mode_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_OWN_NODE   = 1'd0,
		REG_NODE_COUNT = 1'd1
	} reg_addr_t;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'b01,
		SEQ_SCAN = 2'b10
	} seq_t;

endpackage

### hw/rtl/dmn_ifs.sv
interface dmn_in_if import dmn_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [NODE_W-1:0]   peer_node;
	logic [STAMP_W-1:0]  peer_time;

	modport source (output valid, command, peer_node, peer_time, input ready);
	modport sink   (input valid, command, peer_node, peer_time, output ready);
endinterface

interface dmn_out_if import dmn_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   message_kind;
	logic [NODE_W-1:0]   dest_node;
	logic [STAMP_W-1:0]  message_time;
	logic                last_of_run;

	modport source (output valid, message_kind, dest_node, message_time, last_of_run,
		input ready);
	modport sink   (input valid, message_kind, dest_node, message_time, last_of_run,
		output ready);
endinterface

interface dmn_cfg_if import dmn_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_ADDR_W-1:0]  addr;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

### hw/rtl/distributed_mutex_node.sv
// Channel | Dir | Beat contents
// --------+-----+---------------------------------------------------------
// cmd     | in  | command, peer_node, peer_time
// res     | out | message_kind, dest_node, message_time, last_of_run
// cfg     | in  | addr (0 own_node, 1 node_count), data
//
// A peer request, a peer reply, or any command that does nothing yields one
// beat. Want entry, and leave with deferred peers pending, run the node scan:
// it steps through the node slots in order up to the highest node that gets
// a message, with one beat per node messaged. cmd is taken only with the
// sequencer idle and the result register free or draining; a stalled res
// holds the scan.
// arst_n clears the protocol state to released, clock one, bitmaps empty.
module distributed_mutex_node import dmn_pkg::*; #(
	parameter int MAX_NODES  = MAX_NODES_DEF,
	parameter int CLOCK_BITS = CLOCK_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dmn_in_if.sink     cmd,
	dmn_out_if.source  res,
	dmn_cfg_if.sink    cfg
);

	localparam int NODE_SLOTS = (MAX_NODES < NODE_SLOTS_CAP) ? MAX_NODES : NODE_SLOTS_CAP;
	localparam int IDX_W      = $clog2(NODE_SLOTS);
	localparam int EXT_W      = ((CLOCK_BITS > STAMP_W) ? CLOCK_BITS : STAMP_W) + 1;
	localparam logic [CLOCK_BITS-1:0] CLK_MAX   = '1;
	localparam logic [CNT_W-1:0]      CNT_CAP   = CNT_W'(NODE_SLOTS);
	localparam logic [CNT_W-1:0]      CNT_FLOOR = CNT_W'(2);

	// Configuration
	logic [NODE_W-1:0]      own_q;
	logic [CNT_W-1:0]       count_q;

	// Protocol state
	mode_t                  mode_q;
	logic [CLOCK_BITS-1:0]  clock_q;
	logic [STAMP_W-1:0]     own_req_q;
	logic [NODE_SLOTS-1:0]  deferred_q;
	logic [NODE_SLOTS-1:0]  replies_q;

	// Sequencer
	seq_t                   seq_q;
	logic [NODE_SLOTS-1:0]  pend_q;
	logic [IDX_W-1:0]       scan_q;
	kind_t                  scan_kind_q;
	logic [STAMP_W-1:0]     stamp_q;

	// Result register
	logic                   res_valid_q;
	kind_t                  res_kind_q;
	logic [NODE_W-1:0]      res_dest_q;
	logic [STAMP_W-1:0]     res_time_q;
	logic                   res_last_q;

	logic                   slot_free;
	logic                   cmd_fire;
	logic [CNT_W-1:0]       used;
	logic [NODE_SLOTS-1:0]  peers;
	logic [NODE_SLOTS-1:0]  peer_hot;
	logic [NODE_SLOTS-1:0]  scan_hot;
	logic                   peer_ok;
	logic [EXT_W-1:0]       clock_x;
	logic [EXT_W-1:0]       ptime_x;
	logic [EXT_W-1:0]       inc_op;
	logic [EXT_W-1:0]       inc_sum;
	logic [CLOCK_BITS-1:0]  inc_res;
	logic [CLOCK_BITS-1:0]  new_clock;
	logic [EXT_W-1:0]       new_clock_x;
	logic                   defer;
	logic [NODE_SLOTS-1:0]  replies_next;
	logic [NODE_SLOTS-1:0]  leave_pend;
	logic [NODE_SLOTS-1:0]  pend_left;
	logic                   scan_hit;

	assign slot_free = !res_valid_q || res.ready;
	assign cmd.ready = (seq_q == SEQ_IDLE) && slot_free;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	assign res.valid        = res_valid_q;
	assign res.message_kind = res_kind_q;
	assign res.dest_node    = res_dest_q;
	assign res.message_time = res_time_q;
	assign res.last_of_run  = res_last_q;

	// Clamp the participant count to between two and what the bitmaps hold
	always_comb begin
		used = count_q;
		if (used > CNT_CAP) used = CNT_CAP;
		if (used < CNT_FLOOR) used = CNT_FLOOR;
	end

	always_comb begin
		peer_ok = 1'b0;
		for (int j = 0; j < NODE_SLOTS; j++) begin
			peers[j]    = (CNT_W'(j) < used) && (NODE_W'(j) != own_q);
			peer_hot[j] = (cmd.peer_node == NODE_W'(j));
			scan_hot[j] = (scan_q == IDX_W'(j));
			peer_ok     = peer_ok | (peer_hot[j] & peers[j]);
		end
	end

	// Shared saturating incrementer: the peer stamp on a request, the clock
	// during a leave scan
	assign clock_x = EXT_W'(clock_q);
	assign ptime_x = EXT_W'(cmd.peer_time);
	assign inc_op  = (seq_q == SEQ_SCAN) ? clock_x : ptime_x;
	assign inc_sum = inc_op + EXT_W'(1);
	assign inc_res = (inc_sum > EXT_W'(CLK_MAX)) ? CLK_MAX : CLOCK_BITS'(inc_sum);

	// Raise the clock past the peer stamp
	assign new_clock   = (clock_x <= ptime_x) ? inc_res : clock_q;
	assign new_clock_x = EXT_W'(new_clock);

	// Defer when inside, or when waiting with the lower (time, node) pair
	assign defer = (mode_q == MODE_INSIDE) ||
		((mode_q == MODE_WAITING) &&
		 ((own_req_q < cmd.peer_time) ||
		  ((own_req_q == cmd.peer_time) && (own_q < cmd.peer_node))));

	assign replies_next = replies_q | peer_hot;
	assign leave_pend   = deferred_q & peers;
	assign pend_left    = pend_q & ~scan_hot;
	assign scan_hit     = |(pend_q & scan_hot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q       <= '0;
			count_q     <= CNT_W'(2);
			mode_q      <= MODE_RELEASED;
			clock_q     <= CLOCK_BITS'(1);
			own_req_q   <= '0;
			deferred_q  <= '0;
			replies_q   <= '0;
			seq_q       <= SEQ_IDLE;
			pend_q      <= '0;
			scan_q      <= '0;
			scan_kind_q <= KIND_NONE;
			stamp_q     <= '0;
			res_valid_q <= 1'b0;
			res_kind_q  <= KIND_NONE;
			res_dest_q  <= '0;
			res_time_q  <= '0;
			res_last_q  <= 1'b0;
		end else begin
			// Register writes
			if (cfg.valid) begin
				case (reg_addr_t'(cfg.addr))
					REG_OWN_NODE:   own_q   <= cfg.data[NODE_W-1:0];
					REG_NODE_COUNT: count_q <= cfg.data[CNT_W-1:0];
					default: ;
				endcase
			end

			// Drop the result once taken; a new beat below overrides
			if (res.ready) res_valid_q <= 1'b0;

			case (seq_q)
				SEQ_IDLE: begin
					if (cmd_fire) begin
						// Default single beat: no action
						res_valid_q <= 1'b1;
						res_kind_q  <= KIND_NONE;
						res_dest_q  <= '0;
						res_time_q  <= '0;
						res_last_q  <= 1'b1;
						scan_q      <= '0;
						case (cmd_t'(cmd.command))
							CMD_WANT: begin
								if (mode_q == MODE_RELEASED) begin
									// Stamp the request, then scan the peers
									mode_q      <= MODE_WAITING;
									own_req_q   <= clock_x[STAMP_W-1:0];
									stamp_q     <= clock_x[STAMP_W-1:0];
									replies_q   <= '0;
									pend_q      <= peers;
									scan_kind_q <= KIND_REQUEST;
									seq_q       <= SEQ_SCAN;
									res_valid_q <= 1'b0;
								end
							end
							CMD_REQUEST: begin
								if (peer_ok) begin
									clock_q <= new_clock;
									if (defer) begin
										deferred_q <= deferred_q | peer_hot;
									end else begin
										res_kind_q <= KIND_REPLY;
										res_dest_q <= cmd.peer_node;
										res_time_q <= new_clock_x[STAMP_W-1:0];
									end
								end
							end
							CMD_REPLY: begin
								if (peer_ok && (mode_q == MODE_WAITING)) begin
									replies_q <= replies_next;
									if ((replies_next & peers) == peers) begin
										mode_q     <= MODE_INSIDE;
										res_kind_q <= KIND_ENTERED;
										res_dest_q <= own_q;
										res_time_q <= own_req_q;
									end
								end
							end
							CMD_LEAVE: begin
								if (mode_q == MODE_INSIDE) begin
									mode_q     <= MODE_RELEASED;
									deferred_q <= '0;
									// Reply to the deferred peers in node order
									if (|leave_pend) begin
										pend_q      <= leave_pend;
										scan_kind_q <= KIND_REPLY;
										seq_q       <= SEQ_SCAN;
										res_valid_q <= 1'b0;
									end
								end
							end
							default: ;
						endcase
					end
				end
				SEQ_SCAN: begin
					// Skip empty slots; hold on a hit until the result register frees
					if (!scan_hit || slot_free) begin
						scan_q <= scan_q + IDX_W'(1);
						if (scan_hit) begin
							res_valid_q <= 1'b1;
							res_kind_q  <= scan_kind_q;
							res_dest_q  <= NODE_W'(scan_q);
							res_last_q  <= ~|pend_left;
							pend_q      <= pend_left;
							if (scan_kind_q == KIND_REPLY) begin
								res_time_q <= clock_x[STAMP_W-1:0];
								clock_q    <= inc_res;
							end else begin
								res_time_q <= stamp_q;
							end
							if (~|pend_left) seq_q <= SEQ_IDLE;
						end
					end
				end
				default: seq_q <= SEQ_IDLE;
			endcase
		end
	end

endmodule
